// ===== rtl/core/text_console_writer_macros.svh =====
// assertion macros for the text console writer
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define TCW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define TCW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tcw_pkg.sv =====
// shared types and constants of the text console writer
`timescale 1ns / 1ps

package tcw_pkg;

  // field widths
  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;

  // default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // opcodes
  localparam logic [OP_W-1:0] OP_PUT_CHAR   = 2'd0;
  localparam logic [OP_W-1:0] OP_SET_ATTR   = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE_CELL = 2'd2;
  localparam logic [OP_W-1:0] OP_READ_CELL  = 2'd3;

  // character codes
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_LAST  = 8'd126;

  // blank cell: grey on black space
  localparam logic [ATTR_W-1:0] BLANK_ATTR = 8'h07;
  localparam logic [CELL_W-1:0] BLANK_CELL = {BLANK_ATTR, CH_SPACE};

  // command transaction
  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [CHAR_W-1:0] char_code;
    logic [ATTR_W-1:0] attribute;
    logic [COL_W-1:0]  cell_col;
    logic [ROW_W-1:0]  cell_row;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [ATTR_W-1:0] current_attribute;
    logic [CELL_W-1:0] cell_value;
    logic              scrolled;
  } out_item_t;

endpackage

// ===== rtl/core/tcw_channels.sv =====
// valid/ready channel interfaces for commands and results
`timescale 1ns / 1ps

// command channel
interface tcw_in_if import tcw_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// result channel
interface tcw_out_if import tcw_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/tcw_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/text_console_writer.sv =====
// text console writer: cell store, cursor, attribute and scroll sequencer
`timescale 1ns / 1ps
`include "text_console_writer_macros.svh"

// Text console with a COLUMNS x ROWS store of 16-bit cells (attribute in the
// high byte, character in the low byte) held in one single-port-write ram.
// Each command transaction yields one result transaction. A small sequencer
// runs every command: after the address step, put character passes through
// the put state, write cell through the write state, read cell through the
// read and read-wait states, and set attribute goes straight to done. A put
// character that runs off the last row also scrolls: it copies rows
// 1..ROWS-1 up one row and then blanks the last row, with the ram moving one
// cell a cycle.
// After reset the store is filled with blank cells (0x0720) before the
// first command is taken.
// A finished result sits in an output register, so the next command is
// accepted while the previous result still waits to be taken.
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic        clk,
  input  logic        rst_n,
  tcw_in_if.sink      in_chan,
  tcw_out_if.source   out_chan
);

  localparam int CELLS      = COLUMNS * ROWS;
  localparam int MOVE_CELLS = CELLS - COLUMNS;
  localparam int AW         = $clog2(CELLS);
  localparam int CW         = $clog2(COLUMNS);
  localparam int RW         = $clog2(ROWS);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_ADDR   = 10'b0000000100,
    S_PUT    = 10'b0000001000,
    S_WRITE  = 10'b0000010000,
    S_READ   = 10'b0000100000,
    S_RDWAIT = 10'b0001000000,
    S_SCROLL = 10'b0010000000,
    S_BLANK  = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [ATTR_W-1:0] attr_r, attr_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pend_addr_r, pend_addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;
  in_item_t          req_r, req_nxt;
  logic              in_range_r, in_range_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [CELL_W-1:0] value_r, value_nxt;
  logic              scrolled_r, scrolled_nxt;

  logic              in_acc;
  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [CELL_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [AW-1:0]     ram_rd_addr;
  logic [CELL_W-1:0] ram_rd_data;

  logic              cursor_ok;
  logic              scroll_busy;
  logic              parked;
  logic              scroll_result_ok;

  // handshakes
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign in_chan.ready  = (state_r == S_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // cell store
  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // sequencer
  always_comb begin
    logic [RW-1:0] mul_row;
    logic [CW-1:0] mul_col;
    logic [RW:0]   row_w;
    logic [CW:0]   col_w;
    logic          printable;

    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    attr_nxt      = attr_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    req_nxt       = req_r;
    in_range_nxt  = in_range_r;
    addr_nxt      = addr_r;
    value_nxt     = value_r;
    scrolled_nxt  = scrolled_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;

    ram_wr_en   = 1'b0;
    ram_wr_addr = cnt_r;
    ram_wr_data = BLANK_CELL;
    ram_rd_en   = 1'b0;
    ram_rd_addr = addr_r;

    // shared address unit: row * COLUMNS + col
    mul_row = (req_r.opcode == OP_PUT_CHAR) ? row_r : RW'(req_r.cell_row);
    mul_col = (req_r.opcode == OP_PUT_CHAR) ? col_r : CW'(req_r.cell_col);

    printable = (req_r.char_code >= CH_SPACE) && (req_r.char_code <= CH_LAST);
    row_w     = {1'b0, row_r};
    col_w     = {1'b0, col_r};

    unique case (state_r)
      // fill the store with blank cells after reset
      S_CLEAR: begin
        ram_wr_en = 1'b1;
        if (cnt_r == AW'(CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end

      // take a command
      S_IDLE: begin
        if (in_acc) begin
          req_nxt      = in_chan.data;
          in_range_nxt = (32'(in_chan.data.cell_col) < 32'(COLUMNS)) &&
                         (32'(in_chan.data.cell_row) < 32'(ROWS));
          value_nxt    = '0;
          scrolled_nxt = 1'b0;
          state_nxt    = S_ADDR;
        end
      end

      // cell address, decode
      S_ADDR: begin
        addr_nxt = AW'(32'(mul_row) * 32'(COLUMNS) + 32'(mul_col));
        unique case (req_r.opcode)
          OP_PUT_CHAR:   state_nxt = S_PUT;
          OP_SET_ATTR: begin
            attr_nxt  = req_r.attribute;
            state_nxt = S_DONE;
          end
          OP_WRITE_CELL: state_nxt = S_WRITE;
          OP_READ_CELL:  state_nxt = S_READ;
        endcase
      end

      // draw at the cursor and move it
      S_PUT: begin
        ram_wr_en   = printable;
        ram_wr_addr = addr_r;
        ram_wr_data = {attr_r, req_r.char_code};
        if (req_r.char_code == CH_CR) begin
          col_w = '0;
        end else if (req_r.char_code == CH_LF) begin
          row_w = row_w + (RW+1)'(1);
        end else if (printable) begin
          col_w = col_w + (CW+1)'(1);
        end
        if (col_w == (CW+1)'(COLUMNS)) begin
          row_w = row_w + (RW+1)'(1);
          col_w = '0;
        end
        if (row_w == (RW+1)'(ROWS)) begin
          row_nxt      = RW'(ROWS - 1);
          col_nxt      = '0;
          attr_nxt     = BLANK_ATTR;
          scrolled_nxt = 1'b1;
          cnt_nxt      = '0;
          pend_nxt     = 1'b0;
          state_nxt    = S_SCROLL;
        end else begin
          row_nxt   = row_w[RW-1:0];
          col_nxt   = col_w[CW-1:0];
          state_nxt = S_DONE;
        end
      end

      // direct cell write
      S_WRITE: begin
        ram_wr_en   = in_range_r;
        ram_wr_addr = addr_r;
        ram_wr_data = {req_r.attribute, req_r.char_code};
        state_nxt   = S_DONE;
      end

      // direct cell read
      S_READ: begin
        ram_rd_en = in_range_r;
        state_nxt = S_RDWAIT;
      end

      S_RDWAIT: begin
        value_nxt = in_range_r ? ram_rd_data : '0;
        state_nxt = S_DONE;
      end

      // move rows up one: read cell a+COLUMNS, write it to a next cycle
      S_SCROLL: begin
        ram_wr_en   = pend_r;
        ram_wr_addr = pend_addr_r;
        ram_wr_data = ram_rd_data;
        if (cnt_r != AW'(MOVE_CELLS)) begin
          ram_rd_en     = 1'b1;
          ram_rd_addr   = cnt_r + AW'(COLUMNS);
          pend_addr_nxt = cnt_r;
          pend_nxt      = 1'b1;
          cnt_nxt       = cnt_r + AW'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_BLANK;
          end
        end
      end

      // blank the last row
      S_BLANK: begin
        ram_wr_en = 1'b1;
        if (cnt_r == AW'(CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end

      // hand the result to the output register
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt                  = 1'b1;
          out_data_nxt.cursor_row        = ROW_W'(row_r);
          out_data_nxt.cursor_col        = COL_W'(col_r);
          out_data_nxt.current_attribute = attr_r;
          out_data_nxt.cell_value        = value_r;
          out_data_nxt.scrolled          = scrolled_r;
          state_nxt                      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      row_r       <= '0;
      col_r       <= '0;
      attr_r      <= BLANK_ATTR;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      attr_r      <= attr_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    req_r       <= req_nxt;
    in_range_r  <= in_range_nxt;
    addr_r      <= addr_nxt;
    value_r     <= value_nxt;
    scrolled_r  <= scrolled_nxt;
    out_data_r  <= out_data_nxt;
  end

  // check terms
  assign cursor_ok        = (32'(row_r) < 32'(ROWS)) && (32'(col_r) < 32'(COLUMNS));
  assign scroll_busy      = (state_r == S_SCROLL) || (state_r == S_BLANK);
  assign parked           = (row_r == RW'(ROWS - 1)) && (col_r == '0) &&
                            (attr_r == BLANK_ATTR);
  assign scroll_result_ok = (out_data_r.cursor_col == '0) &&
                            (out_data_r.current_attribute == BLANK_ATTR) &&
                            (out_data_r.cell_value == '0);

  // checks
  `TCW_ASSERT_NXT(a_busy_after_accept, in_acc, !in_chan.ready, "ready high after accept")
  `TCW_ASSERT_IMP(a_cursor_in_range, 1'b1, cursor_ok, "cursor out of range")
  `TCW_ASSERT_IMP(a_scroll_cursor, scroll_busy, parked, "cursor not parked during scroll")
  `TCW_ASSERT_IMP(a_scroll_result, out_valid_r && out_data_r.scrolled, scroll_result_ok, "bad scroll result")

endmodule

// ===== test/tcw_console_checker.sv =====
// console checker: predicts each command result and compares it with the block output
`timescale 1ns / 1ps

module tcw_console_checker import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic clk,
  input  logic rst_n,
  tcw_in_if    in_mon,
  tcw_out_if   out_mon,
  output int   fail_count,
  output int   pending,
  output int   checked_count,
  output int   scroll_count
);

  localparam int CELLS = COLUMNS * ROWS;

  // predicted screen, cursor and current attribute
  logic [CELL_W-1:0] screen [CELLS];
  int                cur_row;
  int                cur_col;
  logic [ATTR_W-1:0] cur_attr;

  // results still owed by the block, oldest first
  out_item_t owed_results[$];
  out_item_t want;
  int        errors;
  int        checked;
  int        scrolls;

  // run one command on the predicted console and return its result
  function automatic out_item_t console_step(input in_item_t cmd);
    out_item_t res;
    logic      in_range;
    res      = '0;
    in_range = (cmd.cell_col < COLUMNS) && (cmd.cell_row < ROWS);
    case (cmd.opcode)
      OP_PUT_CHAR: begin
        if (cmd.char_code == CH_CR) begin
          cur_col = 0;
        end else if (cmd.char_code == CH_LF) begin
          cur_row++;
        end else if (cmd.char_code >= CH_SPACE && cmd.char_code <= CH_LAST) begin
          screen[cur_row * COLUMNS + cur_col] = {cur_attr, cmd.char_code};
          cur_col++;
        end
        // column wrap
        if (cur_col >= COLUMNS) begin
          cur_row++;
          cur_col = 0;
        end
        // scroll up one row, blank the last row
        if (cur_row >= ROWS) begin
          for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
          for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = BLANK_CELL;
          cur_attr     = BLANK_ATTR;
          cur_row      = ROWS - 1;
          cur_col      = 0;
          res.scrolled = 1'b1;
        end
      end
      OP_SET_ATTR: begin
        cur_attr = cmd.attribute;
      end
      OP_WRITE_CELL: begin
        if (in_range)
          screen[cmd.cell_row * COLUMNS + cmd.cell_col] = {cmd.attribute, cmd.char_code};
      end
      default: begin
        if (in_range) res.cell_value = screen[cmd.cell_row * COLUMNS + cmd.cell_col];
      end
    endcase
    res.cursor_row        = cur_row[ROW_W-1:0];
    res.cursor_col        = cur_col[COL_W-1:0];
    res.current_attribute = cur_attr;
    return res;
  endfunction

  // compare one result field
  task automatic check_field(input string name, input logic [CELL_W-1:0] exp_val,
                             input logic [CELL_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
      errors++;
    end
  endtask

  initial begin
    errors  = 0;
    checked = 0;
    scrolls = 0;
  end

  // watch both channels
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) screen[i] = BLANK_CELL;
      cur_row  = 0;
      cur_col  = 0;
      cur_attr = BLANK_ATTR;
      owed_results.delete();
    end else begin
      // accepted command transaction
      if (in_mon.valid && in_mon.ready) owed_results.push_back(console_step(in_mon.data));
      // accepted result transaction
      if (out_mon.valid && out_mon.ready) begin
        if (owed_results.size() == 0) begin
          $error("result transaction with no command waiting for it");
          errors++;
        end else begin
          want = owed_results.pop_front();
          check_field("cursor_row", CELL_W'(want.cursor_row),
                      CELL_W'(out_mon.data.cursor_row));
          check_field("cursor_col", CELL_W'(want.cursor_col),
                      CELL_W'(out_mon.data.cursor_col));
          check_field("current_attribute", CELL_W'(want.current_attribute),
                      CELL_W'(out_mon.data.current_attribute));
          check_field("cell_value", want.cell_value, out_mon.data.cell_value);
          check_field("scrolled", CELL_W'(want.scrolled), CELL_W'(out_mon.data.scrolled));
          checked++;
          if (want.scrolled) scrolls++;
        end
      end
    end
    fail_count    <= errors;
    pending       <= owed_results.size();
    checked_count <= checked;
    scroll_count  <= scrolls;
  end

endmodule

// ===== test/tb.sv =====
// testbench top: clock, reset, command stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module tb;
  import tcw_pkg::*;

  localparam int CYCLE_LIMIT   = 10_000_000;
  localparam int PHASE_ITEMS   = 400;
  localparam int DRAIN_CYCLES  = 16;
  localparam int HOLD_CYCLES   = 600;
  localparam int RECENT_WRITES = 16;

  typedef enum int {IDLE_RX_HEAVY, IDLE_TX_HEAVY, IDLE_NONE} idle_mode_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } cell_pos_t;

  logic       clk = 1'b0;
  logic       rst_n;
  idle_mode_t idle_mode    = IDLE_RX_HEAVY;
  logic       hold_request = 1'b0;
  int         fail_count;
  int         pending;
  int         checked_count;
  int         scroll_count;
  int         sent_count   = 0;
  int         read_count   = 0;
  int         cycle_count  = 0;
  cell_pos_t  recent_cells[$];

  tcw_in_if  in_chan ();
  tcw_out_if out_chan ();

  text_console_writer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  tcw_console_checker u_console_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count),
    .scroll_count  (scroll_count)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // receiver: random stalls by mode, plus one long hold-off on request
  initial begin
    int   hold_left;
    logic hold_done;
    logic take;
    hold_left = 0;
    hold_done = 1'b0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        take      = 1'b0;
      end else begin
        case (idle_mode)
          IDLE_RX_HEAVY: take = $urandom_range(99) >= 86;
          IDLE_TX_HEAVY: take = $urandom_range(99) >= 16;
          default:       take = 1'b1;
        endcase
      end
      out_chan.ready <= take;
    end
  end

  function automatic in_item_t make_cmd(input logic [OP_W-1:0] op,
                                        input logic [CHAR_W-1:0] ch,
                                        input logic [ATTR_W-1:0] at,
                                        input logic [COL_W-1:0] col,
                                        input logic [ROW_W-1:0] row);
    in_item_t cmd;
    cmd.opcode    = op;
    cmd.char_code = ch;
    cmd.attribute = at;
    cmd.cell_col  = col;
    cmd.cell_row  = row;
    return cmd;
  endfunction

  // offer one command transaction after a random idle gap, wait for acceptance
  task automatic send_command(input in_item_t cmd);
    int gap;
    int idle_pct;
    gap      = 0;
    idle_pct = (idle_mode == IDLE_RX_HEAVY) ? 16 : (idle_mode == IDLE_TX_HEAVY) ? 86 : 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= cmd;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    sent_count++;
    if (cmd.opcode == OP_READ_CELL) read_count++;
  endtask

  // one random command of any kind
  task automatic send_random_single();
    int        pick;
    in_item_t  cmd;
    cell_pos_t pos;
    pick = $urandom_range(99);
    cmd  = make_cmd(OP_PUT_CHAR, CHAR_W'($urandom_range(CH_LAST, CH_SPACE)),
                    ATTR_W'($urandom()), COL_W'($urandom()), ROW_W'($urandom()));
    if (pick < 40) begin
      // printable character, already set
    end else if (pick < 48) begin
      cmd.char_code = CH_LF;
    end else if (pick < 53) begin
      cmd.char_code = CH_CR;
    end else if (pick < 58) begin
      cmd.char_code = CHAR_W'($urandom_range(255));
    end else if (pick < 70) begin
      cmd.opcode = OP_SET_ATTR;
    end else if (pick < 85) begin
      cmd.opcode = OP_WRITE_CELL;
      if ($urandom_range(99) < 85) begin
        cmd.cell_col = COL_W'($urandom_range(DEF_COLUMNS - 1));
        cmd.cell_row = ROW_W'($urandom_range(DEF_ROWS - 1));
      end
      pos.col = cmd.cell_col;
      pos.row = cmd.cell_row;
      recent_cells.push_back(pos);
      if (recent_cells.size() > RECENT_WRITES) void'(recent_cells.pop_front());
    end else begin
      cmd.opcode = OP_READ_CELL;
      pick = $urandom_range(99);
      if (pick < 40 && recent_cells.size() > 0) begin
        pos          = recent_cells[$urandom_range(recent_cells.size() - 1)];
        cmd.cell_col = pos.col;
        cmd.cell_row = pos.row;
      end else if (pick < 70) begin
        cmd.cell_col = COL_W'($urandom_range(DEF_COLUMNS - 1));
        cmd.cell_row = ROW_W'($urandom_range(DEF_ROWS - 1));
      end else if (pick < 85) begin
        // bottom rows, where printed text piles up after scrolls
        cmd.cell_col = COL_W'($urandom_range(DEF_COLUMNS - 1));
        cmd.cell_row = ROW_W'($urandom_range(DEF_ROWS - 1, DEF_ROWS - 5));
      end
    end
    send_command(cmd);
  endtask

  // a line of text, sometimes longer than the screen width, ended by cr lf
  task automatic send_text_line();
    int             len;
    logic [CHAR_W-1:0] ch;
    len = $urandom_range(100, 1);
    for (int i = 0; i < len; i++) begin
      ch = ($urandom_range(99) < 2) ? CHAR_W'($urandom_range(255))
                                    : CHAR_W'($urandom_range(CH_LAST, CH_SPACE));
      send_command(make_cmd(OP_PUT_CHAR, ch, ATTR_W'($urandom()), COL_W'($urandom()),
                            ROW_W'($urandom())));
    end
    send_command(make_cmd(OP_PUT_CHAR, CH_CR, ATTR_W'($urandom()), COL_W'($urandom()),
                          ROW_W'($urandom())));
    send_command(make_cmd(OP_PUT_CHAR, CH_LF, ATTR_W'($urandom()), COL_W'($urandom()),
                          ROW_W'($urandom())));
  endtask

  // stimulus and verdict
  initial begin
    rst_n         <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reads of blank and out-of-range cells
    send_command(make_cmd(OP_READ_CELL, 8'h00, 8'h00, 7'd0, 5'd0));
    send_command(make_cmd(OP_READ_CELL, 8'h00, 8'h00, 7'd79, 5'd24));
    send_command(make_cmd(OP_READ_CELL, 8'hFF, 8'hFF, 7'd127, 5'd31));
    send_command(make_cmd(OP_READ_CELL, 8'h00, 8'h00, 7'd80, 5'd0));
    send_command(make_cmd(OP_READ_CELL, 8'h00, 8'h00, 7'd0, 5'd25));
    // corner writes, including ignored out-of-range ones
    send_command(make_cmd(OP_WRITE_CELL, 8'hFF, 8'hFF, 7'd0, 5'd0));
    send_command(make_cmd(OP_WRITE_CELL, 8'h00, 8'h00, 7'd79, 5'd24));
    send_command(make_cmd(OP_WRITE_CELL, 8'h41, 8'h1E, 7'd80, 5'd24));
    send_command(make_cmd(OP_WRITE_CELL, 8'hFF, 8'hFF, 7'd127, 5'd31));
    send_command(make_cmd(OP_READ_CELL, 8'h00, 8'h00, 7'd0, 5'd0));
    send_command(make_cmd(OP_READ_CELL, 8'h00, 8'h00, 7'd79, 5'd24));
    send_command(make_cmd(OP_READ_CELL, 8'h00, 8'h00, 7'd0, 5'd24));
    // attribute extremes, printable edges, ignored bytes, cr and lf
    send_command(make_cmd(OP_SET_ATTR, 8'h00, 8'h00, 7'd0, 5'd0));
    send_command(make_cmd(OP_PUT_CHAR, CH_SPACE, 8'h00, 7'd0, 5'd0));
    send_command(make_cmd(OP_SET_ATTR, 8'h00, 8'hFF, 7'd0, 5'd0));
    send_command(make_cmd(OP_PUT_CHAR, CH_LAST, 8'h00, 7'd0, 5'd0));
    send_command(make_cmd(OP_PUT_CHAR, 8'd31, 8'h00, 7'd0, 5'd0));
    send_command(make_cmd(OP_PUT_CHAR, 8'd127, 8'h00, 7'd0, 5'd0));
    send_command(make_cmd(OP_PUT_CHAR, 8'd0, 8'h00, 7'd0, 5'd0));
    send_command(make_cmd(OP_PUT_CHAR, 8'd255, 8'hFF, 7'd127, 5'd31));
    send_command(make_cmd(OP_PUT_CHAR, CH_LF, 8'h00, 7'd0, 5'd0));
    send_command(make_cmd(OP_PUT_CHAR, 8'h41, 8'h00, 7'd0, 5'd0));
    send_command(make_cmd(OP_PUT_CHAR, CH_CR, 8'h00, 7'd0, 5'd0));
    send_command(make_cmd(OP_READ_CELL, 8'h00, 8'h00, 7'd0, 5'd0));
    send_command(make_cmd(OP_READ_CELL, 8'h00, 8'h00, 7'd2, 5'd1));

    // random traffic in three idle modes, long receiver hold-off in the last
    for (int phase = 0; phase < 3; phase++) begin
      idle_mode <= idle_mode_t'(phase);
      if (phase == 2) hold_request <= 1'b1;
      while (sent_count < 25 + (phase + 1) * PHASE_ITEMS) begin
        if ($urandom_range(99) < 3) send_text_line();
        else send_random_single();
      end
    end
    in_chan.valid <= 1'b0;

    // drain
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d commands sent, %0d results checked, %0d cell reads, %0d scrolls",
             sent_count, checked_count, read_count, scroll_count);
    $display("idle modes: receiver heavy, sender heavy, none; one %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
